@@ rtl/ffc_pkg.sv @@
// Shared types and codes for the fixed/float converter pipeline.
`timescale 1ns / 1ps
`default_nettype none
package ffc_pkg;
    typedef enum logic [1:0] {
        OP_I2X = 2'd0,
        OP_F2X = 2'd1,
        OP_X2F = 2'd2,
        OP_X2I = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_NAN = 2'd2;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;
    // largest left shift of the float significand taken by the shift stage; decode saturates larger shifts
    localparam logic signed [9:0] SH_LIMIT = 10'sd8;
    localparam logic [4:0] R_LIMIT = 5'd25;

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic               neg;
        logic               fin;     // result already final
        logic [31:0]        res;
        logic [1:0]         st;
        logic [23:0]        sig;
        logic signed [9:0]  sh;
        logic [31:0]        mag;
    } s1_t;

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic               neg;
        logic               fin;
        logic [31:0]        res;
        logic [1:0]         st;
        logic [32:0]        fmag;    // float to fixed magnitude
        logic [31:0]        norm;    // fixed to float, msb at bit 31
        logic [4:0]         pos;
        logic               zero;
    } s2_t;
endpackage
`default_nettype wire

@@ rtl/ffc_decode.sv @@
// Stage 1: decode, integer ops, float field unpack and specials.
`timescale 1ns / 1ps
`default_nettype none
module ffc_decode
    import ffc_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] operand,
    output s1_t              s1
);
    localparam logic signed [9:0] FB = 10'(FRAC_BITS);

    s1_t s1_reg;
    s1_t s1_next;

    always_comb
    begin
        logic signed [31:0] sv;
        logic [7:0] e;
        sv = $signed(operand);
        e = operand[30:23];
        s1_next = '0;
        s1_next.valid = in_valid;
        s1_next.op = op_t'(op);
        s1_next.neg = operand[31];
        s1_next.sig = {1'b1, operand[22:0]};
        s1_next.sh = $signed({2'b00, e}) - 10'sd150 + FB;
        s1_next.mag = operand[31] ? (32'd0 - operand) : operand;
        s1_next.st = ST_OK;
        case (op_t'(op))
            OP_I2X:
            begin
                s1_next.fin = 1'b1;
                if (((sv <<< FRAC_BITS) >>> FRAC_BITS) != sv)
                begin
                    s1_next.st = ST_SAT;
                    s1_next.res = operand[31] ? NEG_MAX : POS_MAX;
                end
                else
                    s1_next.res = 32'(sv <<< FRAC_BITS);
            end
            OP_F2X:
            begin
                if (e == 8'hFF)
                begin
                    s1_next.fin = 1'b1;
                    if (operand[22:0] != 23'd0)
                    begin
                        s1_next.st = ST_NAN;
                        s1_next.res = 32'd0;
                    end
                    else
                    begin
                        s1_next.st = ST_SAT;
                        s1_next.res = operand[31] ? NEG_MAX : POS_MAX;
                    end
                end
                else if (e == 8'd0)
                begin
                    s1_next.fin = 1'b1;
                    s1_next.res = 32'd0;
                end
                else if (s1_next.sh > SH_LIMIT)
                begin
                    s1_next.fin = 1'b1;
                    s1_next.st = ST_SAT;
                    s1_next.res = operand[31] ? NEG_MAX : POS_MAX;
                end
            end
            OP_X2I:
            begin
                s1_next.fin = 1'b1;
                s1_next.res = 32'(sv >>> FRAC_BITS);
            end
            default: s1_next.fin = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else
            s1_reg <= s1_next;
    end

    assign s1 = s1_reg;
endmodule
`default_nettype wire

@@ rtl/ffc_shift.sv @@
// Stage 2: significand shift for float to fixed, normalize for fixed to float.
`timescale 1ns / 1ps
`default_nettype none
module ffc_shift
    import ffc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  s1_t       s1,
    output s2_t       s2
);
    s2_t s2_reg;
    s2_t s2_next;

    always_comb
    begin
        logic [32:0] sig33;
        logic signed [9:0] nsh;
        logic [4:0] r;
        logic [4:0] p;
        sig33 = {9'd0, s1.sig};
        nsh = -s1.sh;
        r = nsh[4:0];
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (s1.mag[i])
                p = 5'(i);
        end
        s2_next.valid = s1.valid;
        s2_next.op = s1.op;
        s2_next.neg = s1.neg;
        s2_next.fin = s1.fin;
        s2_next.res = s1.res;
        s2_next.st = s1.st;
        s2_next.pos = p;
        s2_next.zero = (s1.mag == 32'd0);
        s2_next.norm = s1.mag << (5'd31 - p);
        if (!s1.sh[9])
            s2_next.fmag = sig33 << s1.sh[3:0];
        else if (nsh > $signed({5'd0, R_LIMIT}))
            s2_next.fmag = 33'd0;
        else
            s2_next.fmag = (sig33 + (33'd1 << (r - 5'd1))) >> r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_reg <= '0;
        else
            s2_reg <= s2_next;
    end

    assign s2 = s2_reg;
endmodule
`default_nettype wire

@@ rtl/ffc_round.sv @@
// Stage 3: rounding, exponent, saturation and sign apply; output register.
`timescale 1ns / 1ps
`default_nettype none
module ffc_round
    import ffc_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  s2_t              s2,
    output logic             done,
    output logic [31:0]      result,
    output logic [1:0]       status
);
    localparam logic [8:0] EXP_OFS = 9'(127 - FRAC_BITS);

    logic        done_reg;
    logic [31:0] result_reg;
    logic [1:0]  status_reg;
    logic [31:0] result_next;
    logic [1:0]  status_next;

    always_comb
    begin
        logic        up;
        logic [24:0] sig;
        logic [5:0]  p;
        logic [8:0]  ex;
        up = s2.norm[7] && ((s2.norm[6:0] != 7'd0) || s2.norm[8]);
        sig = {1'b0, s2.norm[31:8]} + {24'd0, up};
        p = {1'b0, s2.pos};
        if (sig[24])
        begin
            sig = sig >> 1;
            p = p + 6'd1;
        end
        ex = {3'd0, p} + EXP_OFS;
        result_next = s2.res;
        status_next = s2.st;
        if (!s2.fin)
        begin
            if (s2.op == OP_X2F)
                result_next = s2.zero ? 32'd0 : {s2.neg, ex[7:0], sig[22:0]};
            else if (!s2.neg)
            begin
                if (s2.fmag > {1'b0, POS_MAX})
                begin
                    status_next = ST_SAT;
                    result_next = POS_MAX;
                end
                else
                    result_next = s2.fmag[31:0];
            end
            else if (s2.fmag > {1'b0, NEG_MAX})
            begin
                status_next = ST_SAT;
                result_next = NEG_MAX;
            end
            else
                result_next = 32'd0 - s2.fmag[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s2.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign done = done_reg;
    assign result = result_reg;
    assign status = status_reg;
endmodule
`default_nettype wire

@@ rtl/float_fixed_point_converter_unit.sv @@
// Top level of the fixed-point / single-precision float converter.
//
//  channel   signals                 direction  beat taken when
//  command   start, op, operand      in         start && !busy
//  result    done, result, status    out        done (one cycle)
//
// Three-stage pipeline: an accepted beat is registered in decode, then shift,
// then round, where done rises together with its result and status.
// One beat per cycle; busy stays low, since every stage advances each cycle.
// The stage registers and done clear on reset; result and status do not.
// The receiver cannot stall, so nothing is held back in the pipe.
`timescale 1ns / 1ps
`default_nettype none
module float_fixed_point_converter_unit
    import ffc_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] operand,
    output logic             done,
    output logic [31:0]      result,
    output logic [1:0]       status
);
    s1_t s1;
    s2_t s2;

    assign busy = 1'b0;

    ffc_decode #(.FRAC_BITS(FRAC_BITS)) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .op       (op),
        .operand  (operand),
        .s1       (s1)
    );

    ffc_shift u_shift (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    ffc_round #(.FRAC_BITS(FRAC_BITS)) u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .s2     (s2),
        .done   (done),
        .result (result),
        .status (status)
    );
endmodule
`default_nettype wire

@@ rtl/ffc_checker.sv @@
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ffc_checker
    import ffc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  op,
    input wire logic        done,
    input wire logic [1:0]  status
);
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted beat did not complete in three cycles");

    a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(start, 3))
        else $error("done without a matching beat");

    a_stcode: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_SAT || status == ST_NAN))
        else $error("illegal status code");

    a_fixedops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_X2F || op == OP_X2I)) |-> ##3 (status == ST_OK))
        else $error("nonzero status on fixed to float or fixed to int");
endmodule

bind float_fixed_point_converter_unit ffc_checker u_ffc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .op     (op),
    .done   (done),
    .status (status)
);
`default_nettype wire
